[rtl/core/life_cell_next_state_stream_core_defines.svh]
// ----------------------------------------------------------------------------
// life cell stream core - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_CELL_NEXT_STATE_STREAM_CORE_DEFINES_SVH
`define LIFE_CELL_NEXT_STATE_STREAM_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LCNS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LCNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define LCNS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/core/lcns_pkg.sv]
// ----------------------------------------------------------------------------
// lcns_pkg
// Types, sizes and life rule helpers for the life cell stream core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcns_pkg;

  // grid limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // size register width, row counter width, column and address width
  localparam int DIM_W     = 11;
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int OUT_IDX_W = 10;

  // result queue sizing
  localparam int MAX_RESULTS    = 2;
  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_FIFO_PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int RES_FIFO_CNT_W = $clog2(RES_FIFO_DEPTH + 1);
  localparam int RES_FIFO_ROOM  = RES_FIFO_DEPTH - 2 * MAX_RESULTS;

  // item function codes
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // one line buffer entry: row r-1 and row r-2 of a column
  typedef struct packed {
    logic cur;
    logic above;
  } col_t;

  // one result item
  typedef struct packed {
    logic                 cell_next;
    logic [OUT_IDX_W-1:0] out_row;
    logic [OUT_IDX_W-1:0] out_col;
    logic                 frame_done;
    logic                 last;
  } res_t;

  // up to two results pushed per cycle, first slot filled first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t d0;
    res_t d1;
  } push_t;

  // clamp a size register to 1..lim
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    if (v == '0) return DIM_W'(1);
    if (v > lim) return lim;
    return v;
  endfunction

  // survive with 2 or 3, birth with exactly 3
  function automatic logic life_rule(input logic center, input logic [3:0] n);
    if (center) return (n == 4'd2) || (n == 4'd3);
    return n == 4'd3;
  endfunction

  // next state of the middle cell of a 3x3 window
  function automatic logic window_next(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 9; k++) n = n + 4'(w[k]);
    n = n - 4'(w[4]);
    return life_rule(w[4], n);
  endfunction

endpackage

`default_nettype wire

[rtl/core/lcns_stream_if.sv]
// ----------------------------------------------------------------------------
// lcns stream interfaces
// Valid/ready channels for cell items in and next-state results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// cell item channel
interface lcns_in_if;
  logic valid;
  logic ready;
  logic func;
  logic cell_in;

  modport source (output valid, output func, output cell_in, input ready);
  modport sink   (input valid, input func, input cell_in, output ready);
endinterface

// result item channel
interface lcns_out_if;
  logic       valid;
  logic       ready;
  logic       cell_next;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       frame_done;
  logic       last;

  modport source (output valid, output cell_next, output out_row, output out_col,
                  output frame_done, output last, input ready);
  modport sink   (input valid, input cell_next, input out_row, input out_col,
                  input frame_done, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/life_cell_next_state_stream_core.sv]
// ----------------------------------------------------------------------------
// life_cell_next_state_stream_core
// One generation of the game of life over a raster cell stream.
// ----------------------------------------------------------------------------
// Items on in_ch carry func and cell_in. A load item (func 0) brings the next
// cell of the grid in raster order; once all rows are in, one drain item
// (func 1) per column brings out the last row. Loads after the last row and
// drains before it are taken and dropped. Each item gives zero, one or two
// results on out_ch; the last of them has last set, and the final cell of the
// grid has frame_done set.
// Grid size is written on the cfg port while the block is idle; a write also
// restarts the frame. Sizes of 0 count as 1, above 1024 as 1024.
// One item is taken per clock while the queue has room and cfg_we is low. A
// result passes the stage register and the queue before it leaves. The rate
// is set by the single line buffer memory, read once per item, written once per load.
// A small result queue separates the sides: when the receiver stalls, in_ch
// keeps taking items until more than four results wait, then ready drops.
// Reset clears all control state; the line buffer needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "life_cell_next_state_stream_core_defines.svh"

module life_cell_next_state_stream_core import lcns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [DIM_W-1:0] cfg_wdata,
  lcns_in_if.sink          in_ch,
  lcns_out_if.source       out_ch
);

  // size registers
  logic [DIM_W-1:0] grid_w_r, grid_h_r;
  logic [DIM_W-1:0] grid_w_m1, grid_h_m1;

  // frame position
  logic [ROW_W-1:0] load_row_r, load_row_nxt;
  logic [COL_W-1:0] load_col_r, load_col_nxt;
  logic [COL_W-1:0] drain_col_r, drain_col_nxt;

  // accept stage
  logic             accept, is_drain, load_ok, drain_ok, take;
  logic [DIM_W-1:0] drain_next, load_next;
  logic             drain_nb;
  logic [COL_W-1:0] rd_addr;
  logic             fwd_hit;

  // line buffer memory
  col_t             line_mem [MAX_WIDTH];
  col_t             mem_q_r;
  logic             mem_we;
  col_t             wr_data;

  // compute stage
  logic             s1_valid_r, s1_drain_r, s1_cell_r, s1_nb_r, s1_fwd_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  col_t             s1_fwd_data_r;
  logic [8:0]       window_r, win_base, win_new;
  col_t             dwin_lo_r, dwin_hi_r, head_r;
  col_t             rd_col, col_dm, col_d, col_dp;
  logic             a_bit, m_bit, emit1, emit2, row_end;
  logic [ROW_W-1:0] row_m1;
  logic [3:0]       drain_n;
  res_t             res1, res2, res_drain;
  push_t            push;
  logic [RES_FIFO_CNT_W-1:0] fifo_count;

  assign grid_w_m1 = grid_w_r - DIM_W'(1);
  assign grid_h_m1 = grid_h_r - DIM_W'(1);

  // accept decision and line buffer read address
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !cfg_we && (fifo_count <= RES_FIFO_CNT_W'(RES_FIFO_ROOM));
  assign is_drain    = in_ch.func == FUNC_DRAIN;
  assign load_ok     = (DIM_W'(load_row_r) < grid_h_r) && (DIM_W'(load_col_r) < grid_w_r);
  assign drain_ok    = (DIM_W'(load_row_r) >= grid_h_r) && (DIM_W'(drain_col_r) < grid_w_r);
  assign take        = accept && (is_drain ? drain_ok : load_ok);
  assign drain_next  = DIM_W'(drain_col_r) + DIM_W'(1);
  assign load_next   = DIM_W'(load_col_r) + DIM_W'(1);
  assign drain_nb    = drain_next < grid_w_r;
  assign rd_addr     = is_drain ? drain_next[COL_W-1:0] : load_col_r;
  assign fwd_hit     = mem_we && (s1_col_r == rd_addr);

  // frame position update
  always_comb begin
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    drain_col_nxt = drain_col_r;
    if (take && !is_drain) begin
      if (load_next >= grid_w_r) begin
        load_col_nxt = '0;
        load_row_nxt = load_row_r + ROW_W'(1);
      end else begin
        load_col_nxt = load_next[COL_W-1:0];
      end
    end else if (take && is_drain) begin
      if (drain_nb) begin
        drain_col_nxt = drain_next[COL_W-1:0];
      end else begin
        load_row_nxt  = '0;
        drain_col_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r    <= DIM_W'(MAX_WIDTH);
      grid_h_r    <= DIM_W'(MAX_HEIGHT);
      load_row_r  <= '0;
      load_col_r  <= '0;
      drain_col_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_GRID_WIDTH) begin
        grid_w_r <= eff_size(cfg_wdata, DIM_W'(MAX_WIDTH));
      end else begin
        grid_h_r <= eff_size(cfg_wdata, DIM_W'(MAX_HEIGHT));
      end
      load_row_r  <= '0;
      load_col_r  <= '0;
      drain_col_r <= '0;
    end else begin
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      drain_col_r <= drain_col_nxt;
    end
  end

  // stage register between read and compute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_drain_r    <= is_drain;
      s1_cell_r     <= in_ch.cell_in;
      s1_row_r      <= load_row_r;
      s1_col_r      <= is_drain ? drain_col_r : load_col_r;
      s1_nb_r       <= drain_nb;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= wr_data;
    end
  end

  // line buffer: one read, one write per cycle
  assign mem_we = s1_valid_r && !s1_drain_r;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[s1_col_r] <= wr_data;
    if (take) mem_q_r <= line_mem[rd_addr];
  end

  // load path: shift the column into the window
  always_comb begin
    rd_col   = s1_fwd_r ? s1_fwd_data_r : mem_q_r;
    a_bit    = (s1_row_r >= ROW_W'(2)) ? rd_col.above : 1'b0;
    m_bit    = (s1_row_r >= ROW_W'(1)) ? rd_col.cur : 1'b0;
    wr_data  = '{cur: s1_cell_r, above: m_bit};
    win_base = (s1_col_r == '0) ? 9'd0 : window_r;
    win_new  = {s1_cell_r, m_bit, a_bit, win_base[8:3]};
    row_m1   = s1_row_r - ROW_W'(1);
    row_end  = DIM_W'(s1_col_r) == grid_w_m1;
    emit1    = (s1_row_r >= ROW_W'(1)) && (s1_col_r >= COL_W'(1));
    emit2    = (s1_row_r >= ROW_W'(1)) && row_end;

    res1.cell_next  = window_next(win_new);
    res1.out_row    = row_m1[OUT_IDX_W-1:0];
    res1.out_col    = OUT_IDX_W'(s1_col_r - COL_W'(1));
    res1.frame_done = 1'b0;
    res1.last       = !emit2;

    res2.cell_next  = window_next({3'b000, win_new[8:3]});
    res2.out_row    = row_m1[OUT_IDX_W-1:0];
    res2.out_col    = OUT_IDX_W'(s1_col_r);
    res2.frame_done = 1'b0;
    res2.last       = 1'b1;
  end

  // drain path: last two rows, columns d-1, d and d+1
  always_comb begin
    col_dm  = (s1_col_r == '0) ? '0 : dwin_lo_r;
    col_d   = (s1_col_r == '0) ? head_r : dwin_hi_r;
    col_dp  = s1_nb_r ? rd_col : '0;
    drain_n = 4'(col_dm.above) + 4'(col_d.above) + 4'(col_dp.above)
            + 4'(col_dm.cur) + 4'(col_dp.cur);

    res_drain.cell_next  = life_rule(col_d.cur, drain_n);
    res_drain.out_row    = grid_h_m1[OUT_IDX_W-1:0];
    res_drain.out_col    = OUT_IDX_W'(s1_col_r);
    res_drain.frame_done = row_end;
    res_drain.last       = 1'b1;
  end

  // results into the queue, in order
  always_comb begin
    push = '0;
    if (s1_valid_r && s1_drain_r) begin
      push.v0 = 1'b1;
      push.d0 = res_drain;
    end else if (s1_valid_r) begin
      push.v0 = emit1 || emit2;
      push.v1 = emit1 && emit2;
      push.d0 = emit1 ? res1 : res2;
      push.d1 = res2;
    end
  end

  // window, drain window and first-column capture of the last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_we) begin
      window_r <= '0;
    end else if (mem_we) begin
      window_r <= win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_drain_r) begin
      dwin_lo_r <= col_d;
      dwin_hi_r <= col_dp;
    end
    if (mem_we && (s1_col_r == '0) && (DIM_W'(s1_row_r) == grid_h_m1)) begin
      head_r <= wr_data;
    end
  end

  lcns_result_fifo u_result_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .count  (fifo_count),
    .out_ch (out_ch)
  );

  // checks
  `LCNS_ASSERT_NEXT(a_cfg_restart, cfg_we, (load_row_r == '0) && (drain_col_r == '0) && !s1_valid_r, "config write did not restart the frame")
  `LCNS_ASSERT_IMPLY(a_pair_at_row_end, push.v1, s1_valid_r && !s1_drain_r && row_end, "two results away from a row end")
  `LCNS_ASSERT_IMPLY(a_first_row_silent, s1_valid_r && !s1_drain_r && (s1_row_r == '0), !push.v0, "result from a first row load")

endmodule

`default_nettype wire

[rtl/core/lcns_result_fifo.sv]
// ----------------------------------------------------------------------------
// lcns_result_fifo
// Result queue taking up to two items per cycle and giving one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "life_cell_next_state_stream_core_defines.svh"

module lcns_result_fifo import lcns_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  push_t                     push,
  output logic [RES_FIFO_CNT_W-1:0] count,
  lcns_out_if.source                out_ch
);

  res_t                      fifo_mem [RES_FIFO_DEPTH];
  logic [RES_FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [RES_FIFO_CNT_W-1:0] push_cnt;
  logic                      pop;
  res_t                      head;

  // pointer and fill bookkeeping
  assign pop      = out_ch.valid && out_ch.ready;
  assign push_cnt = RES_FIFO_CNT_W'(push.v0) + RES_FIFO_CNT_W'(push.v1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_FIFO_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + RES_FIFO_PTR_W'(pop);
    count_nxt  = count_r + push_cnt - RES_FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, second item goes behind the first
  always_ff @(posedge clk) begin
    if (push.v0) fifo_mem[wr_ptr_r] <= push.d0;
    if (push.v1) fifo_mem[wr_ptr_r + RES_FIFO_PTR_W'(1)] <= push.d1;
  end

  // head of queue drives the channel
  assign head              = fifo_mem[rd_ptr_r];
  assign count             = count_r;
  assign out_ch.valid      = count_r != '0;
  assign out_ch.cell_next  = head.cell_next;
  assign out_ch.out_row    = head.out_row;
  assign out_ch.out_col    = head.out_col;
  assign out_ch.frame_done = head.frame_done;
  assign out_ch.last       = head.last;

  // checks
  `LCNS_ASSERT_NEVER(a_fifo_overflow, (count_r + push_cnt) > RES_FIFO_CNT_W'(RES_FIFO_DEPTH), "result queue overflow")
  `LCNS_ASSERT_IMPLY(a_fifo_push_order, push.v1, push.v0, "second slot pushed without first")
  `LCNS_ASSERT_NEXT(a_fifo_count_step, !push.v0 && !pop, count_r == $past(count_r), "count moved without push or pop")

endmodule

`default_nettype wire
